// ===== design/srdve_pkg.sv =====
// Shared types, constants and helper functions for the sample record
// delta varint encoder. No dependencies.
package srdve_pkg;

	localparam int WORD_W     = 64;
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 4;
	localparam int NUM_FIELDS = 4;
	localparam int CMD_DEPTH  = 2;

	localparam logic [BYTE_W-1:0] REC_TYPE_SAMPLES = 8'd2;
	localparam logic [LEN_W-1:0]  WORD_BYTES       = 4'd8;
	localparam logic [1:0]        VALUE_FIELD      = 2'd3;

	// One classified sample handed from the front end to the serializer.
	// vlen holds the byte count of each field; the value field is always a word.
	typedef struct packed {
		logic                                  first;
		logic [NUM_FIELDS-1:0][LEN_W-1:0]      vlen;
		logic [NUM_FIELDS-1:0][WORD_W-1:0]     word;
	} cmd_t;

	function automatic logic [WORD_W-1:0] zigzag(input logic [WORD_W-1:0] d);
		return {d[WORD_W-2:0], 1'b0} ^ {WORD_W{d[WORD_W-1]}};
	endfunction

	// Number of 7-bit groups needed to carry z, 1 to 10.
	function automatic logic [LEN_W-1:0] varint_len(input logic [WORD_W-1:0] z);
		logic [LEN_W-1:0] n;
		n = LEN_W'(1);
		for (int k = 1; k < 10; k++) begin
			if ((z >> (7 * k)) != '0) begin
				n = LEN_W'(k + 1);
			end
		end
		return n;
	endfunction

endpackage

// ===== design/sample_record_delta_varint_encoder_unit.sv =====
// Top level of the sample record delta varint encoder.
// Depends on srdve_pkg, srdve_front, srdve_cmd_fifo and srdve_back.
//
// Each sample pushed in comes out as a byte stream on the result queue: a
// sample that starts a record gives 33 bytes (type byte, then four big-endian
// words) and a continuing sample gives 11 to 38 bytes (three zigzag varint
// deltas against the record bases, then the value word); last_byte marks the
// final byte of each sample. The byte serializer emits one beat per cycle unless
// a held output byte is not popped, and a queued sample's first byte follows the
// previous sample's last byte directly. The front end takes a new sample every cycle
// until the one-stage delta register and the CMD_DEPTH-entry command queue are
// full; a pushed sample passes the delta register, the command queue and the
// serializer state before its first byte reaches the output register.
module sample_record_delta_varint_encoder_unit
	import srdve_pkg::*;
#(
	parameter int CMD_DEPTH = srdve_pkg::CMD_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [WORD_W-1:0]        series_ref,
	input  logic [WORD_W-1:0]        entity_id,
	input  logic signed [WORD_W-1:0] timestamp,
	input  logic [WORD_W-1:0]        value_bits,
	input  logic                     first_of_record,
	output logic                     empty,
	input  logic                     pop,
	output logic [BYTE_W-1:0]        out_byte,
	output logic                     last_byte
);

	cmd_t fr_cmd;
	cmd_t bk_cmd;
	logic fr_push;
	logic q_full;
	logic q_empty;
	logic bk_pop;

	srdve_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.series_ref      (series_ref),
		.entity_id       (entity_id),
		.timestamp       (timestamp),
		.value_bits      (value_bits),
		.first_of_record (first_of_record),
		.cmd_push        (fr_push),
		.cmd_full        (q_full),
		.cmd             (fr_cmd)
	);

	srdve_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.full   (q_full),
		.wdata  (fr_cmd),
		.pop    (bk_pop),
		.empty  (q_empty),
		.rdata  (bk_cmd)
	);

	srdve_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (bk_cmd),
		.cmd_empty (q_empty),
		.cmd_pop   (bk_pop),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule

// ===== design/srdve_front.sv =====
// Front end: accepts samples, keeps the record bases, and for continuing samples
// forms deltas and zigzag codes with their varint lengths. Depends on srdve_pkg.
module srdve_front
	import srdve_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [WORD_W-1:0]        series_ref,
	input  logic [WORD_W-1:0]        entity_id,
	input  logic signed [WORD_W-1:0] timestamp,
	input  logic [WORD_W-1:0]        value_bits,
	input  logic                     first_of_record,
	output logic                     cmd_push,
	input  logic                     cmd_full,
	output cmd_t                     cmd
);

	logic                valid_s1;
	logic                first_s1;
	logic [WORD_W-1:0]   ref_s1;
	logic [WORD_W-1:0]   lid_s1;
	logic [WORD_W-1:0]   ts_s1;
	logic [WORD_W-1:0]   val_s1;
	logic [WORD_W-1:0]   base_ref_q;
	logic [WORD_W-1:0]   base_logical_q;
	logic [WORD_W-1:0]   base_time_q;
	logic                accept;

	assign full     = valid_s1 && cmd_full;
	assign accept   = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			base_ref_q     <= '0;
			base_logical_q <= '0;
			base_time_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (!cmd_full) begin
				valid_s1 <= 1'b0;
			end
			if (accept && first_of_record) begin
				base_ref_q     <= series_ref;
				base_logical_q <= entity_id;
				base_time_q    <= $unsigned(timestamp);
			end
		end
	end

	// Differences wrap modulo 2^64; a first sample passes its raw words.
	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1 <= first_of_record;
			val_s1   <= value_bits;
			if (first_of_record) begin
				ref_s1 <= series_ref;
				lid_s1 <= entity_id;
				ts_s1  <= $unsigned(timestamp);
			end else begin
				ref_s1 <= series_ref - base_ref_q;
				lid_s1 <= entity_id - base_logical_q;
				ts_s1  <= $unsigned(timestamp) - base_time_q;
			end
		end
	end

	always_comb begin
		cmd.first   = first_s1;
		cmd.word[3] = val_s1;
		cmd.vlen[3] = WORD_BYTES;
		if (first_s1) begin
			cmd.word[0] = ref_s1;
			cmd.word[1] = lid_s1;
			cmd.word[2] = ts_s1;
			cmd.vlen[0] = WORD_BYTES;
			cmd.vlen[1] = WORD_BYTES;
			cmd.vlen[2] = WORD_BYTES;
		end else begin
			cmd.word[0] = zigzag(ref_s1);
			cmd.word[1] = zigzag(lid_s1);
			cmd.word[2] = zigzag(ts_s1);
			cmd.vlen[0] = varint_len(cmd.word[0]);
			cmd.vlen[1] = varint_len(cmd.word[1]);
			cmd.vlen[2] = varint_len(cmd.word[2]);
		end
	end

endmodule

// ===== design/srdve_cmd_fifo.sv =====
// Short command queue between front end and serializer.
// Depends on srdve_pkg for the command type.
module srdve_cmd_fifo
	import srdve_pkg::*;
#(
	parameter int DEPTH = CMD_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  cmd_t wdata,
	input  logic pop,
	output logic empty,
	output cmd_t rdata
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr;
	logic             rd;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("command queue count beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with unequal pointers");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("command queue lost a write");

endmodule

// ===== design/srdve_back.sv =====
// Serializer: turns queued commands into bytes, one beat per cycle unless a held
// output byte is not popped, through a single output register. Depends on srdve_pkg.
module srdve_back
	import srdve_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output logic              empty,
	input  logic              pop,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last_byte
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_TYPE = 3'b010,
		ST_BODY = 3'b100
	} bk_state_t;

	bk_state_t                         state_q;
	logic                              first_q;
	logic [1:0]                        field_q;
	logic [LEN_W-1:0]                  count_q;
	logic [WORD_W-1:0]                 work_q;
	logic [NUM_FIELDS-1:0][WORD_W-1:0] words_q;
	logic [NUM_FIELDS-1:0][LEN_W-1:0]  vlen_q;
	logic                              out_valid_q;
	logic [BYTE_W-1:0]                 out_byte_q;
	logic                              last_q;

	logic              is_var;
	logic              field_end;
	logic              rec_end;
	logic              emit;
	logic              load;
	logic [1:0]        nxt_field;
	logic [BYTE_W-1:0] byte_val;

	assign is_var    = !first_q && (field_q != VALUE_FIELD);
	assign field_end = (state_q == ST_BODY) && (count_q == LEN_W'(1));
	assign rec_end   = field_end && (field_q == VALUE_FIELD);
	assign emit      = (!out_valid_q || pop) && (state_q != ST_IDLE);
	assign load      = !cmd_empty && ((state_q == ST_IDLE) || (emit && rec_end));
	assign nxt_field = field_q + 2'd1;
	assign cmd_pop   = load;

	always_comb begin
		case (state_q)
			ST_TYPE: byte_val = REC_TYPE_SAMPLES;
			ST_BODY: begin
				if (is_var) begin
					byte_val = {count_q != LEN_W'(1), work_q[6:0]};
				end else begin
					byte_val = work_q[WORD_W-1 -: BYTE_W];
				end
			end
			default: byte_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_q <= 1'b0;
			field_q <= '0;
			count_q <= '0;
		end else if (load) begin
			state_q <= cmd.first ? ST_TYPE : ST_BODY;
			first_q <= cmd.first;
			field_q <= '0;
			count_q <= cmd.vlen[0];
		end else if (emit) begin
			case (state_q)
				ST_TYPE: state_q <= ST_BODY;
				ST_BODY: begin
					if (rec_end) begin
						state_q <= ST_IDLE;
					end else if (field_end) begin
						field_q <= nxt_field;
						count_q <= vlen_q[nxt_field];
					end else begin
						count_q <= count_q - 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Varints drain from the low end, words from the high end.
	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= cmd.word;
			vlen_q  <= cmd.vlen;
			work_q  <= cmd.word[0];
		end else if (emit && (state_q == ST_BODY)) begin
			if (field_end) begin
				work_q <= words_q[nxt_field];
			end else if (is_var) begin
				work_q <= work_q >> 7;
			end else begin
				work_q <= work_q << BYTE_W;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_val;
			last_q     <= rec_end;
		end
	end

	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BODY) |-> (count_q != '0))
		else $error("serializer field count hit zero");

	a_type_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TYPE) |-> first_q)
		else $error("type byte on a continuing sample");

	a_value_len: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_BODY) && (field_q == VALUE_FIELD)) |-> (count_q <= WORD_BYTES))
		else $error("value word longer than eight bytes");

endmodule
